// ===== hdl/oca_pkg.sv =====
// oca_pkg: shared constants, command codes, state type and control structs
// for the organ combination action block; no dependencies
`default_nettype none

package oca_pkg;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int BANK_W   = 4;
    localparam int PISTON_W = 3;
    localparam int GROUP_W  = 3;
    localparam int BUTTON_W = 4;
    localparam int STOP_W   = 16;
    localparam int ADDR_W   = BANK_W + PISTON_W;
    localparam int STORE_AW = ADDR_W + GROUP_W;

    // storage sizes
    localparam int LIVE_DEPTH  = 2 ** GROUP_W;
    localparam int COMBOS      = 2 ** ADDR_W;
    localparam int STORE_DEPTH = 2 ** STORE_AW;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_FIELD_W = GROUP_W + STOP_W + 1 + BANK_W + PISTON_W;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W = 2;

    // parameter defaults
    localparam int DEF_BANKS           = 16;
    localparam int DEF_PISTONS         = 8;
    localparam int DEF_GROUPS          = 8;
    localparam int DEF_STOPS_PER_GROUP = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PANIC  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET,
        ST_RD,
        ST_WR,
        ST_EMIT,
        ST_PANIC
    } state_t;

    typedef struct packed {
        logic               capture;
        logic               cancel;
        logic               toggle;
        logic               activate;
        logic               mark_valid;
        logic               store_wr;
        logic               store_rd;
        logic               load_live;
        logic               emit_group;
        logic               emit_panic;
        logic [GROUP_W-1:0] cnt;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             set_ok;
        logic             recall_ok;
        logic             toggle_ok;
        logic             out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/oca_ctrl.sv =====
// oca_ctrl: command sequencer for the combination action block
// depends on oca_pkg; drives the datapath through ctrl_t, reads stat_t
`default_nettype none

module oca_ctrl #(
    parameter int GROUPS = oca_pkg::DEF_GROUPS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire oca_pkg::stat_t stat,
    output oca_pkg::ctrl_t      ctrl
);

    import oca_pkg::*;

    localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(GROUPS - 1);

    state_t             state_reg, state_next;
    logic [GROUP_W-1:0] cnt_reg, cnt_next;
    logic               cnt_last;

    assign cnt_last = (cnt_reg == LAST_GROUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                cnt_next = '0;
                unique case (stat.cmd)
                    CMD_CANCEL: state_next = ST_EMIT;
                    CMD_SET:    state_next = stat.set_ok ? ST_SET : ST_IDLE;
                    CMD_RECALL: state_next = stat.recall_ok ? ST_RD : ST_IDLE;
                    CMD_TOGGLE: state_next = stat.toggle_ok ? ST_EMIT : ST_IDLE;
                    CMD_PANIC:  state_next = ST_PANIC;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_SET:
            begin
                if (cnt_last)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (cnt_last)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_RD;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (cnt_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PANIC:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl          = '0;
        ctrl.cnt      = cnt_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctrl.capture  = s_axis_tvalid;
            end
            ST_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_CANCEL: ctrl.cancel = 1'b1;
                    CMD_SET:
                    begin
                        ctrl.activate   = stat.set_ok;
                        ctrl.mark_valid = stat.set_ok;
                    end
                    CMD_RECALL: ctrl.activate = stat.recall_ok;
                    CMD_TOGGLE: ctrl.toggle = stat.toggle_ok;
                    default:    ctrl.cancel = 1'b0;
                endcase
            end
            ST_SET:   ctrl.store_wr   = 1'b1;
            ST_RD:    ctrl.store_rd   = 1'b1;
            ST_WR:    ctrl.load_live  = 1'b1;
            ST_EMIT:  ctrl.emit_group = stat.out_free;
            ST_PANIC: ctrl.emit_panic = stat.out_free;
            default:  ctrl.cnt        = cnt_reg;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/oca_datapath.sv =====
// oca_datapath: live stops, combination memory, valid marks, active register
// and output register; depends on oca_pkg, commanded by oca_ctrl
`default_nettype none

module oca_datapath #(
    parameter int BANKS           = oca_pkg::DEF_BANKS,
    parameter int PISTONS         = oca_pkg::DEF_PISTONS,
    parameter int GROUPS          = oca_pkg::DEF_GROUPS,
    parameter int STOPS_PER_GROUP = oca_pkg::DEF_STOPS_PER_GROUP
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [oca_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [oca_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  wire oca_pkg::ctrl_t                  ctrl,
    output oca_pkg::stat_t                       stat,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [oca_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic [oca_pkg::M_TUSER_W-1:0]        m_axis_tuser,
    output logic                                 m_axis_tlast
);

    import oca_pkg::*;

    localparam logic [BANK_W:0]     BANK_LIM   = (BANK_W + 1)'(BANKS);
    localparam logic [PISTON_W:0]   PISTON_LIM = (PISTON_W + 1)'(PISTONS);
    localparam logic [GROUP_W:0]    GROUP_LIM  = (GROUP_W + 1)'(GROUPS);
    localparam logic [BUTTON_W:0]   BUTTON_LIM = (BUTTON_W + 1)'(STOPS_PER_GROUP);
    localparam logic [STOP_W-1:0]   STOP_MASK  = STOP_W'((2 ** STOPS_PER_GROUP) - 1);
    localparam logic [GROUP_W-1:0]  LAST_GROUP = GROUP_W'(GROUPS - 1);

    // latched transaction
    logic [CMD_W-1:0]    cmd_reg;
    logic [BANK_W-1:0]   bank_reg;
    logic [PISTON_W-1:0] piston_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic [BUTTON_W-1:0] button_reg;

    logic [STOP_W-1:0]   live_reg [LIVE_DEPTH];
    logic [COMBOS-1:0]   valid_reg;
    logic                active_flag_reg;
    logic [ADDR_W-1:0]   active_addr_reg;

    logic [STOP_W-1:0]   combo_store [STORE_DEPTH];
    logic [STOP_W-1:0]   rdata_reg;

    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic                out_last_reg;

    logic [ADDR_W-1:0]   addr;
    logic [STORE_AW-1:0] store_addr;
    logic [STOP_W-1:0]   flip;
    logic                range_ok;
    logic                out_free;

    assign addr       = {bank_reg, piston_reg};
    assign store_addr = {addr, ctrl.cnt};
    assign flip       = STOP_MASK & (STOP_W'(1) << button_reg);
    assign range_ok   = ({1'b0, bank_reg} < BANK_LIM) && ({1'b0, piston_reg} < PISTON_LIM);
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign stat.cmd       = cmd_reg;
    assign stat.set_ok    = range_ok;
    assign stat.recall_ok = range_ok && valid_reg[addr];
    assign stat.toggle_ok = ({1'b0, group_reg} < GROUP_LIM) && ({1'b0, button_reg} < BUTTON_LIM);
    assign stat.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg    <= s_axis_tuser;
            bank_reg   <= s_axis_tdata[3:0];
            piston_reg <= s_axis_tdata[6:4];
            group_reg  <= s_axis_tdata[9:7];
            button_reg <= s_axis_tdata[13:10];
        end
    end

    // live stop groups
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < LIVE_DEPTH; g++)
                live_reg[g] <= '0;
        end
        else
        begin
            for (int g = 0; g < LIVE_DEPTH; g++)
            begin
                if (ctrl.cancel)
                    live_reg[g] <= '0;
                else if (ctrl.toggle && (group_reg == GROUP_W'(g)))
                    live_reg[g] <= (live_reg[g] ^ flip) & STOP_MASK;
                else if (ctrl.load_live && (ctrl.cnt == GROUP_W'(g)))
                    live_reg[g] <= rdata_reg & STOP_MASK;
            end
        end
    end

    // valid marks and active combination
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            active_flag_reg <= 1'b0;
            active_addr_reg <= '0;
        end
        else
        begin
            if (ctrl.mark_valid)
                valid_reg[addr] <= 1'b1;
            if (ctrl.cancel)
            begin
                active_flag_reg <= 1'b0;
                active_addr_reg <= '0;
            end
            else if (ctrl.activate)
            begin
                active_flag_reg <= 1'b1;
                active_addr_reg <= addr;
            end
        end
    end

    // combination memory
    always_ff @(posedge clk)
    begin
        if (ctrl.store_wr)
            combo_store[store_addr] <= live_reg[ctrl.cnt];
        if (ctrl.store_rd)
            rdata_reg <= combo_store[store_addr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit_group || ctrl.emit_panic)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_group)
        begin
            out_data_reg <= {{M_PAD_W{1'b0}}, active_addr_reg[PISTON_W-1:0],
                             active_addr_reg[ADDR_W-1:PISTON_W], active_flag_reg,
                             live_reg[ctrl.cnt], ctrl.cnt};
            out_user_reg <= {1'b0, (cmd_reg == CMD_CANCEL)};
            out_last_reg <= (ctrl.cnt == LAST_GROUP);
        end
        else if (ctrl.emit_panic)
        begin
            out_data_reg <= {{M_PAD_W{1'b0}}, active_addr_reg[PISTON_W-1:0],
                             active_addr_reg[ADDR_W-1:PISTON_W], active_flag_reg,
                             {STOP_W{1'b0}}, {GROUP_W{1'b0}}};
            out_user_reg <= 2'b10;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    a_panic_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit_panic |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser[1]
                             && (m_axis_tdata[18:0] == 19'd0)))
        else $error("panic result malformed");

    a_store_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.store_wr |-> (valid_reg[addr] && active_flag_reg))
        else $error("store write before valid mark");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_live |-> (valid_reg[addr] && active_flag_reg
                            && (active_addr_reg == addr)))
        else $error("recall load from unmarked combination");

    a_emit_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit_group && (ctrl.cnt != LAST_GROUP)) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("last marker on a middle group");

endmodule

`default_nettype wire

// ===== hdl/organ_combination_action_top.sv =====
// organ_combination_action_top: top level of the combination action block
// depends on oca_pkg, oca_ctrl and oca_datapath
//
// One command at a time is taken on the slave stream; s_axis_tready is high only
// while no command is being worked. Cancel and toggle emit one result per group; set
// does one memory write per group, then emits one result per group; recall does a
// registered memory read and a load per group, then emits; panic emits one result.
// A stalled m_axis_tready holds the emit and panic states. The single port of the
// combination memory and the one output register make the groups go one at a time.
// Every state change emits GROUPS results, group 0 first, with tlast on the final
// one; a recall miss or an unknown command emits nothing.
`default_nettype none

module organ_combination_action_top #(
    parameter int BANKS           = oca_pkg::DEF_BANKS,
    parameter int PISTONS         = oca_pkg::DEF_PISTONS,
    parameter int GROUPS          = oca_pkg::DEF_GROUPS,
    parameter int STOPS_PER_GROUP = oca_pkg::DEF_STOPS_PER_GROUP
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // bank[3:0], piston[6:4], group[9:7], button[13:10], zero[15:14]
    input  wire logic [oca_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[2:0]
    input  wire logic [oca_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // group_index[2:0], stop_bits[18:3], combo_active[19], active_bank[23:20],
    // active_piston[26:24], zero[31:27]
    output logic [oca_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // cancel_pulse[0], sound_off[1]
    output logic [oca_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                               m_axis_tlast
);

    import oca_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    oca_ctrl #(
        .GROUPS (GROUPS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .ctrl          (ctrl)
    );

    oca_datapath #(
        .BANKS           (BANKS),
        .PISTONS         (PISTONS),
        .GROUPS          (GROUPS),
        .STOPS_PER_GROUP (STOPS_PER_GROUP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .ctrl          (ctrl),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
